// File: hdl/assert_macros.svh
// Assertion macros shared by the circular peak picker RTL.
// No dependencies; the assertions drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked only while out of reset.
`define CPP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define CPP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CPP_ASSERT(lbl, clk, rstn, prop, msg)
`define CPP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: hdl/cpp_pkg.sv
// Package for the circular peak picker: field widths, register indexes,
// reset values, controller states and the controller/datapath interface types.
// No dependencies.
`default_nettype none

package cpp_pkg;

    localparam int ANGLE_BINS_DEF = 360;
    localparam int MAX_PEAKS_DEF  = 4;

    localparam int LEVEL_W     = 16;
    localparam int ANGLE_W     = 9;
    localparam int TOTAL_W     = 3;
    localparam int LIMIT_W     = 3;
    localparam int SEP_W       = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_ADDR_W  = 1;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_PAD_W   = OUT_TDATA_W - ANGLE_W - TOTAL_W;

    localparam logic [LIMIT_W-1:0] PEAK_LIMIT_RST = 3'd1;
    localparam logic [SEP_W-1:0]   MIN_SEP_RST    = 8'd20;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PEAK_LIMIT     = 1'b0,
        REG_MIN_SEPARATION = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CHECK,
        ST_SCAN,
        ST_EMIT
    } cpp_state_t;

    typedef struct packed {
        logic load;        // store the accepted level
        logic last;        // the accepted level closes the spectrum
        logic scan_start;  // begin one pass over the store
        logic commit;      // insert the best candidate into the peak list
        logic emit_start;  // present the first result transaction
    } cpp_cmd_t;

    typedef struct packed {
        logic need_more;   // fewer peaks chosen than the limit
        logic scan_done;   // the pass has visited every bin
        logic have;        // the pass found a candidate
        logic emit_done;   // the last result transaction was taken
    } cpp_sts_t;

endpackage

`default_nettype wire

// File: hdl/circular_peak_picker.sv
// Top level of the circular peak picker: stream ports, configuration port,
// controller and datapath. Depends on cpp_pkg, cpp_ctrl, cpp_datapath, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// The block takes one circular spectrum as a stream of levels, one per angle
// starting at -ANGLE_BINS/2 degrees, with tlast on the final level. Levels are
// accepted one per cycle and written to an internal memory. After tlast the
// block picks up to peak_limit peaks (at most MAX_PEAKS): each pick round is
// one pass over the memory, which holds the best local maximum that keeps at
// least min_separation degrees of circular distance from the peaks already
// chosen; equal levels go to the lower angle. There is one round per peak plus
// one more when the search stops for lack of candidates. The peaks then leave
// as one transaction each, in ascending angle order and at up to one per cycle,
// with tlast on the last; a spectrum without peaks gives a single transaction
// with tuser low. No level is accepted from tlast until the last result
// transaction has been taken. A spectrum shorter than ANGLE_BINS levels is
// searched over the whole memory, older levels included. Configuration writes
// take effect at once and belong between spectra, while the block is idle.

module circular_peak_picker
    import cpp_pkg::*;
#(
    parameter int ANGLE_BINS = ANGLE_BINS_DEF,
    parameter int MAX_PEAKS  = MAX_PEAKS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wen,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [LEVEL_W-1:0]     s_tdata,    // [15:0] level
    input  wire logic                   s_tlast,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,    // [8:0] peak_angle, [11:9] peak_total
    output logic                        m_tuser,    // [0] found
    output logic                        m_tlast
);

    cpp_cmd_t cmd;
    cpp_sts_t sts;

    cpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cpp_datapath #(
        .ANGLE_BINS (ANGLE_BINS),
        .MAX_PEAKS  (MAX_PEAKS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .level     (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

    // A pending result and an open input side never coexist.
    `CPP_ASSERT_ALWAYS(a_no_overlap, clk, m_tvalid |-> !s_tready, "input open while results pending")
    `CPP_ASSERT(a_tail_ends, clk, rst_n, (m_tvalid && m_tready && m_tlast) |=> !m_tvalid, "result after tail")
    `CPP_ASSERT(a_none_is_tail, clk, rst_n, (m_tvalid && !m_tuser) |-> m_tlast, "none-found item not last")

endmodule

`default_nettype wire

// File: hdl/cpp_ctrl.sv
// Controller state machine of the circular peak picker: loading, pick rounds
// and result output. Depends on cpp_pkg.
`default_nettype none

module cpp_ctrl
    import cpp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    input  wire logic     s_tlast,
    output logic          s_tready,
    input  wire cpp_sts_t sts,
    output cpp_cmd_t      cmd
);

    cpp_state_t state_reg;
    cpp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    cmd.last = s_tlast;
                    if (s_tlast)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (sts.need_more)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    if (sts.have)
                    begin
                        cmd.commit = 1'b1;
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (sts.emit_done)
                begin
                    state_next = ST_LOAD;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/cpp_datapath.sv
// Datapath of the circular peak picker: spectrum memory, scan window, candidate
// test, sorted peak list and output register. Depends on cpp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cpp_datapath
    import cpp_pkg::*;
#(
    parameter int ANGLE_BINS = ANGLE_BINS_DEF,
    parameter int MAX_PEAKS  = MAX_PEAKS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wen,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic [LEVEL_W-1:0]     level,
    input  wire logic                   m_tready,
    output logic                        m_tvalid,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic                        m_tuser,
    output logic                        m_tlast,
    input  wire cpp_cmd_t               cmd,
    output cpp_sts_t                    sts
);

    localparam int IDX_W = $clog2(ANGLE_BINS);
    localparam int CNT_W = $clog2(ANGLE_BINS + 3);
    localparam int PK_W  = $clog2(MAX_PEAKS + 1);
    localparam int LI_W  = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int SW    = (IDX_W > SEP_W) ? IDX_W : SEP_W;
    localparam int LW    = (PK_W > LIMIT_W) ? PK_W : LIMIT_W;
    localparam int AW    = (IDX_W + 1 > ANGLE_W) ? IDX_W + 1 : ANGLE_W;
    localparam int TW    = (PK_W > TOTAL_W) ? PK_W : TOTAL_W;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ANGLE_BINS - 1);
    localparam logic [IDX_W-1:0] HALF_BINS = IDX_W'(ANGLE_BINS / 2);
    localparam logic [IDX_W-1:0] BINS_MOD  = IDX_W'(ANGLE_BINS);
    localparam logic [CNT_W-1:0] RD_END    = CNT_W'(ANGLE_BINS + 1);
    localparam logic [CNT_W-1:0] RX_END    = CNT_W'(ANGLE_BINS + 2);
    localparam logic [CNT_W-1:0] RX_FIRST  = CNT_W'(3);
    localparam logic [LW-1:0]    LIMIT_MAX = LW'(MAX_PEAKS);
    localparam logic [AW-1:0]    ANG_OFS   = AW'(ANGLE_BINS / 2);

    // Configuration registers.
    logic [LIMIT_W-1:0] peak_limit_reg;
    logic [SEP_W-1:0]   min_sep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_limit_reg <= PEAK_LIMIT_RST;
            min_sep_reg    <= MIN_SEP_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                REG_PEAK_LIMIT:     peak_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_MIN_SEPARATION: min_sep_reg    <= cfg_wdata[SEP_W-1:0];
            endcase
        end
    end

    // Load pointer; a spectrum that runs long wraps over its oldest values.
    logic [IDX_W-1:0] ld_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_idx_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (cmd.last || (ld_idx_reg == LAST_IDX))
            begin
                ld_idx_reg <= '0;
            end
            else
            begin
                ld_idx_reg <= ld_idx_reg + 1'b1;
            end
        end
    end

    // Spectrum memory, up to one write and one registered read per cycle.
    logic [LEVEL_W-1:0] spec_mem [ANGLE_BINS];
    logic [LEVEL_W-1:0] mem_q_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [CNT_W-1:0]   rd_cnt_m1;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            spec_mem[ld_idx_reg] <= level;
        end
        mem_q_reg <= spec_mem[rd_addr];
    end

    // Scan sequencer. The pass reads the last bin, then bins 0 to N-1, then bin 0
    // again, so the three-value window sees both circular neighbors of every bin.
    logic             rd_active_reg;
    logic [CNT_W-1:0] rd_cnt_reg;
    logic             q_valid_reg;
    logic [CNT_W-1:0] rx_cnt_reg;
    logic             win_new_reg;
    logic             scan_done_reg;
    logic             have_reg;
    logic             eval;
    logic             take;

    always_comb
    begin
        rd_cnt_m1 = rd_cnt_reg - 1'b1;
        if (rd_cnt_reg == '0)
        begin
            rd_addr = LAST_IDX;
        end
        else if (rd_cnt_reg == RD_END)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = rd_cnt_m1[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_active_reg <= 1'b0;
            rd_cnt_reg    <= '0;
            q_valid_reg   <= 1'b0;
            rx_cnt_reg    <= '0;
            win_new_reg   <= 1'b0;
            scan_done_reg <= 1'b0;
            have_reg      <= 1'b0;
        end
        else
        begin
            q_valid_reg   <= rd_active_reg;
            win_new_reg   <= q_valid_reg;
            scan_done_reg <= eval && (rx_cnt_reg == RX_END);
            if (cmd.scan_start)
            begin
                rd_active_reg <= 1'b1;
                rd_cnt_reg    <= '0;
                rx_cnt_reg    <= '0;
                have_reg      <= 1'b0;
            end
            else
            begin
                if (rd_active_reg)
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (rd_cnt_reg == RD_END)
                    begin
                        rd_active_reg <= 1'b0;
                    end
                end
                if (q_valid_reg)
                begin
                    rx_cnt_reg <= rx_cnt_reg + 1'b1;
                end
                if (take)
                begin
                    have_reg <= 1'b1;
                end
            end
        end
    end

    // Window and best candidate.
    logic [LEVEL_W-1:0] prev_reg;
    logic [LEVEL_W-1:0] cur_reg;
    logic [LEVEL_W-1:0] nxt_reg;
    logic [LEVEL_W-1:0] best_val_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [CNT_W-1:0]   rx_m3;
    logic [IDX_W-1:0]   cand_idx;

    // Sorted peak list and its fill count.
    logic [IDX_W-1:0] list_reg [MAX_PEAKS];
    logic [PK_W-1:0]  chosen_cnt_reg;

    logic [IDX_W-1:0]   diff_a [MAX_PEAKS];
    logic [IDX_W-1:0]   dist_a [MAX_PEAKS];
    logic [MAX_PEAKS-1:0] blocked;
    logic               local_max;
    logic               sep_ok;

    assign eval     = win_new_reg && (rx_cnt_reg >= RX_FIRST);
    assign rx_m3    = rx_cnt_reg - RX_FIRST;
    assign cand_idx = rx_m3[IDX_W-1:0];

    // One lane per chosen peak: circular distance to the candidate.
    always_comb
    begin
        for (int j = 0; j < MAX_PEAKS; j++)
        begin
            if (cand_idx > list_reg[j])
            begin
                diff_a[j] = cand_idx - list_reg[j];
            end
            else
            begin
                diff_a[j] = list_reg[j] - cand_idx;
            end
            dist_a[j] = (diff_a[j] > HALF_BINS) ? (BINS_MOD - diff_a[j]) : diff_a[j];
            blocked[j] = (PK_W'(j) < chosen_cnt_reg) &&
                         ((dist_a[j] == '0) || (SW'(dist_a[j]) < SW'(min_sep_reg)));
        end
    end

    assign local_max = (cur_reg >= prev_reg) && (cur_reg >= nxt_reg);
    assign sep_ok    = ~|blocked;
    assign take      = eval && local_max && sep_ok &&
                       (!have_reg || (cur_reg > best_val_reg));

    always_ff @(posedge clk)
    begin
        if (q_valid_reg)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= nxt_reg;
            nxt_reg  <= mem_q_reg;
        end
        if (take)
        begin
            best_val_reg <= cur_reg;
            best_idx_reg <= cand_idx;
        end
    end

    // Insertion keeps the list in ascending bin order. Entries below the new
    // peak stay, the new peak lands at the first larger one, the rest move up.
    logic [MAX_PEAKS:0] lt_ext;
    logic [IDX_W-1:0]   sh_a  [MAX_PEAKS];
    logic [IDX_W-1:0]   ins_a [MAX_PEAKS];

    always_comb
    begin
        lt_ext[0] = 1'b1;
        sh_a[0]   = best_idx_reg;
        for (int j = 1; j < MAX_PEAKS; j++)
        begin
            sh_a[j] = list_reg[j-1];
        end
        for (int j = 0; j < MAX_PEAKS; j++)
        begin
            lt_ext[j+1] = (PK_W'(j) < chosen_cnt_reg) && (list_reg[j] < best_idx_reg);
        end
        for (int j = 0; j < MAX_PEAKS; j++)
        begin
            if (lt_ext[j+1])
            begin
                ins_a[j] = list_reg[j];
            end
            else if (lt_ext[j])
            begin
                ins_a[j] = best_idx_reg;
            end
            else
            begin
                ins_a[j] = sh_a[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            list_reg <= ins_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chosen_cnt_reg <= '0;
        end
        else if (cmd.load && cmd.last)
        begin
            chosen_cnt_reg <= '0;
        end
        else if (cmd.commit)
        begin
            chosen_cnt_reg <= chosen_cnt_reg + 1'b1;
        end
    end

    logic [LW-1:0] limit_sat;

    assign limit_sat = (LW'(peak_limit_reg) > LIMIT_MAX) ? LIMIT_MAX : LW'(peak_limit_reg);

    // Output register.
    logic                 out_valid_reg;
    logic [ANGLE_W-1:0]   out_angle_reg;
    logic                 out_found_reg;
    logic [TOTAL_W-1:0]   out_total_reg;
    logic                 out_tail_reg;
    logic [PK_W-1:0]      ptr_reg;
    logic [PK_W-1:0]      sel_ptr;
    logic [PK_W-1:0]      ptr_inc;
    logic [LI_W-1:0]      sel_li;
    logic                 none;
    logic [AW-1:0]        ang_ext;
    logic [TW-1:0]        tot_ext;
    logic                 out_take;
    logic                 load_item;

    assign sel_ptr   = cmd.emit_start ? '0 : ptr_reg;
    assign ptr_inc   = sel_ptr + 1'b1;
    assign sel_li    = sel_ptr[LI_W-1:0];
    assign none      = (chosen_cnt_reg == '0);
    assign ang_ext   = AW'(list_reg[sel_li]) - ANG_OFS;
    assign tot_ext   = TW'(chosen_cnt_reg);
    assign out_take  = out_valid_reg && m_tready;
    assign load_item = cmd.emit_start || (out_take && !out_tail_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ptr_reg       <= '0;
        end
        else
        begin
            if (cmd.emit_start)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take && out_tail_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load_item)
            begin
                ptr_reg <= ptr_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            out_angle_reg <= none ? '0 : ang_ext[ANGLE_W-1:0];
            out_found_reg <= !none;
            out_total_reg <= tot_ext[TOTAL_W-1:0];
            out_tail_reg  <= none || (ptr_inc == chosen_cnt_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_total_reg, out_angle_reg};
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_tail_reg;

    assign sts.need_more = LW'(chosen_cnt_reg) < limit_sat;
    assign sts.scan_done = scan_done_reg;
    assign sts.have      = have_reg;
    assign sts.emit_done = out_take && out_tail_reg;

    `CPP_ASSERT(a_cnt_bound, clk, rst_n, chosen_cnt_reg <= PK_W'(MAX_PEAKS), "peak count above maximum")
    `CPP_ASSERT(a_commit_has_best, clk, rst_n, cmd.commit |-> have_reg, "commit without a candidate")
    `CPP_ASSERT(a_emit_free, clk, rst_n, cmd.emit_start |-> !out_valid_reg, "emit start over a pending result")

endmodule

`default_nettype wire
